[hdl/mibe_pkg.sv]
package mibe_pkg;

  localparam int unsigned WordBitsDef = 64;
  localparam int unsigned CfgIdxBits  = 1;

  typedef enum logic [CfgIdxBits-1:0] {
    REG_MODULUS = 1'b0,
    REG_NINV    = 1'b1
  } cfg_reg_e;

  // datapath operations
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_MUL_Q,
    OP_MUL_QM,
    OP_REDC_FIN,
    OP_SUB_MOD,
    OP_EUC_INIT,
    OP_EUC_STEP,
    OP_FIX_U,
    OP_MUL_QV,
    OP_MUL_QVM,
    OP_VAR_FIN,
    OP_FAIL
  } dp_op_e;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_LOAD,
    ST_CHECK,
    ST_C_MQ,
    ST_C_MQM,
    ST_C_FIN,
    ST_C_SUB,
    ST_C_CHK,
    ST_E_INIT,
    ST_E_STEP,
    ST_E_END,
    ST_F_MQ,
    ST_F_MQM,
    ST_F_FIN,
    ST_V_CHK,
    ST_V_MQ,
    ST_V_MQM,
    ST_V_FIN,
    ST_FAIL,
    ST_OUT
  } ctl_state_e;

  typedef struct packed {
    dp_op_e op;
  } dp_cmd_t;

  typedef struct packed {
    logic in_range;
    logic y_bad;
    logic euc_done;
    logic gcd_one;
    logic t_ge_w;
    logic mul_last;
    logic conv_pass;
  } dp_status_t;

endpackage

[hdl/mibe_datapath.sv]
module mibe_datapath
  import mibe_pkg::*;
#(
  parameter int unsigned WORD_BITS = WordBitsDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  dp_cmd_t          cmd_i,
  input  logic             mode_i,
  input  logic [63:0]      operand_i,
  input  logic [63:0]      modulus_i,
  input  logic [63:0]      ninv_i,
  output dp_status_t       status_o,
  output logic [63:0]      inverse_o,
  output logic             ok_o
);

  localparam int unsigned W  = WORD_BITS;
  localparam int unsigned TW = $clog2(4 * W + 2) + 1;
  localparam int unsigned SW = $clog2(W);

  logic [W-1:0]   m_q, ninv_q, x_q, y_q, u_q, v_q, q_q;
  logic [2*W-1:0] p_q;
  logic [TW-1:0]  t_q;
  logic [63:0]    a_q;
  logic           mode_q, ok_q, conv_q;

  // running reduction input and its source
  logic [W-1:0]   redc_x;
  logic [2*W-1:0] prod;
  logic [W-1:0]   mul_a, mul_b;
  logic [W-1:0]   y_red, u_red_full;
  logic [W:0]     lsum;
  logic [W-1:0]   vmask;
  logic [SW:0]    tsh;
  logic [W-1:0]   y_sh, y_ctz_in;
  logic [SW-1:0]  y_s;

  // multiplier: four 32x32 partial products, one per cycle
  logic           mul_op, mul_last;
  logic [1:0]     mc_q;
  logic [127:0]   acc_q, acc_sum, pp_sh;
  logic [63:0]    a64, b64, pp;
  logic [31:0]    a_dig, b_dig;
  logic [1:0]     pp_pos;

  // count trailing zeros, capped at W-1
  function automatic logic [SW-1:0] ctz(input logic [W-1:0] val);
    logic [SW-1:0] n;
    n = SW'(W - 1);
    for (int i = W - 1; i >= 0; i--) begin
      if (val[i]) n = SW'(i);
    end
    return n;
  endfunction

  // euclid step signals
  logic [W-1:0]  e_diff, e_sh, e_sum, e_other_sh;
  logic [SW-1:0] e_s;
  logic          e_xgt;

  assign e_xgt      = x_q > y_q;
  assign e_diff     = e_xgt ? x_q - y_q : y_q - x_q;
  assign e_s        = ctz(e_diff);
  assign e_sh       = e_diff >> e_s;
  assign e_sum      = u_q + v_q;
  assign e_other_sh = (e_xgt ? u_q : v_q) << e_s;

  assign mul_a = (cmd_i.op == OP_MUL_Q || cmd_i.op == OP_MUL_QV) ? redc_x : q_q;
  assign mul_b = (cmd_i.op == OP_MUL_Q || cmd_i.op == OP_MUL_QV) ? ninv_q : m_q;

  // partial product accumulation, full product valid in the last cycle
  assign mul_op   = (cmd_i.op == OP_MUL_Q || cmd_i.op == OP_MUL_QM ||
                     cmd_i.op == OP_MUL_QV || cmd_i.op == OP_MUL_QVM);
  assign mul_last = (mc_q == 2'd3);
  assign a64      = 64'(mul_a);
  assign b64      = 64'(mul_b);
  assign a_dig    = mc_q[0] ? a64[63:32] : a64[31:0];
  assign b_dig    = mc_q[1] ? b64[63:32] : b64[31:0];
  assign pp       = 64'(a_dig) * 64'(b_dig);
  assign pp_pos   = {mc_q[0] & mc_q[1], mc_q[0] ^ mc_q[1]};
  assign pp_sh    = {64'd0, pp} << {pp_pos, 5'd0};
  assign acc_sum  = ((mc_q == 2'd0) ? 128'd0 : acc_q) + pp_sh;
  assign prod     = acc_sum[2*W-1:0];

  assign redc_x = (cmd_i.op == OP_MUL_QV || cmd_i.op == OP_MUL_QVM ||
                   cmd_i.op == OP_VAR_FIN || conv_q == 1'b0) ? u_q : y_q;

  assign tsh   = t_q[SW:0];
  assign vmask = (W'(1) << tsh[SW-1:0]) - W'(1);
  assign lsum  = {1'b0, p_q[W-1:0]} + {1'b0, u_q};

  assign y_ctz_in = y_q;
  assign y_s      = ctz(y_ctz_in);
  assign y_sh     = y_q >> y_s;

  assign u_red_full = p_q[2*W-1:W] + W'(redc_x != '0);
  assign y_red      = u_red_full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ok_q   <= 1'b0;
      conv_q <= 1'b0;
      mc_q   <= 2'd0;
    end else begin
      unique case (cmd_i.op)
        OP_LOAD:   begin ok_q <= 1'b0; conv_q <= mode_i; end
        OP_EUC_INIT: conv_q <= 1'b0;
        OP_VAR_FIN:  ok_q <= 1'b1;
        OP_FAIL:     ok_q <= 1'b0;
        default: ;
      endcase
      if (mul_op) mc_q <= mc_q + 2'd1;
    end
  end

  // partial product accumulator
  always_ff @(posedge clk_i) begin
    if (mul_op) acc_q <= acc_sum;
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      OP_LOAD: begin
        m_q    <= modulus_i[W-1:0];
        ninv_q <= ninv_i[W-1:0];
        a_q    <= operand_i;
        mode_q <= mode_i;
        y_q    <= operand_i[W-1:0];
      end
      OP_MUL_Q:   if (mul_last) q_q <= prod[W-1:0];
      OP_MUL_QV:  if (mul_last) q_q <= prod[W-1:0] & vmask;
      OP_MUL_QM, OP_MUL_QVM: if (mul_last) p_q <= prod;
      OP_REDC_FIN: begin
        if (conv_q) y_q <= y_red;
        else begin
          u_q <= u_red_full;
          t_q <= t_q - TW'(W);
        end
      end
      OP_SUB_MOD: if (y_q >= m_q) y_q <= y_q - m_q;
      OP_EUC_INIT: begin
        x_q <= m_q;
        u_q <= W'(1);
        v_q <= '0;
        y_q <= y_sh;
        t_q <= TW'(y_s);
      end
      OP_EUC_STEP: begin
        t_q <= t_q + TW'(e_s);
        if (e_xgt) begin
          x_q <= e_sh;
          v_q <= e_sum;
          u_q <= e_other_sh;
        end else begin
          y_q <= e_sh;
          u_q <= e_sum;
          v_q <= e_other_sh;
        end
      end
      OP_FIX_U: if (!u_q[0]) u_q <= m_q - v_q;
      OP_VAR_FIN: begin
        if (t_q != '0) begin
          u_q <= W'(({(lsum[W] ? p_q[2*W-1:W] + W'(1) : p_q[2*W-1:W]),
                      lsum[W-1:0]}) >> tsh);
        end
      end
      default: ;
    endcase
  end

  // status to the controller
  assign status_o.in_range  = (m_q[0] == 1'b1) && (a_q != '0) &&
                              (a_q < 64'(m_q));
  assign status_o.y_bad     = (y_q == '0) || (y_q >= m_q);
  assign status_o.euc_done  = (x_q == y_q);
  assign status_o.gcd_one   = (x_q == W'(1));
  assign status_o.t_ge_w    = t_q >= TW'(W);
  assign status_o.mul_last  = mul_last;
  assign status_o.conv_pass = mode_q;

  assign inverse_o = ok_q ? 64'(u_q) : '0;
  assign ok_o      = ok_q;

endmodule

[hdl/mibe_ctrl.sv]
module mibe_ctrl
  import mibe_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  input  dp_status_t status_i,
  output dp_cmd_t    cmd_o
);

  ctl_state_e state_q, state_d;
  logic       pass_q, pass_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      pass_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      pass_q  <= pass_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    pass_d  = pass_q;
    unique case (state_q)
      ST_IDLE:  if (in_valid_i) state_d = ST_LOAD;
      ST_LOAD:  state_d = ST_CHECK;
      ST_CHECK: begin
        pass_d = 1'b0;
        if (!status_i.in_range) state_d = ST_FAIL;
        else if (status_i.conv_pass) state_d = ST_C_MQ;
        else state_d = ST_E_INIT;
      end
      ST_C_MQ:  if (status_i.mul_last) state_d = ST_C_MQM;
      ST_C_MQM: if (status_i.mul_last) state_d = ST_C_FIN;
      ST_C_FIN: state_d = ST_C_SUB;
      ST_C_SUB: begin
        pass_d  = ~pass_q;
        state_d = pass_q ? ST_C_CHK : ST_C_MQ;
      end
      ST_C_CHK:  state_d = status_i.y_bad ? ST_FAIL : ST_E_INIT;
      ST_E_INIT: state_d = ST_E_STEP;
      ST_E_STEP: state_d = status_i.euc_done ? ST_E_END : ST_E_STEP;
      ST_E_END:  state_d = status_i.gcd_one ? ST_F_MQ : ST_FAIL;
      ST_F_MQ: begin
        if (!status_i.t_ge_w) state_d = ST_V_CHK;
        else if (status_i.mul_last) state_d = ST_F_MQM;
      end
      ST_F_MQM:  if (status_i.mul_last) state_d = ST_F_FIN;
      ST_F_FIN:  state_d = ST_F_MQ;
      ST_V_CHK:  state_d = ST_V_MQ;
      ST_V_MQ:   if (status_i.mul_last) state_d = ST_V_MQM;
      ST_V_MQM:  if (status_i.mul_last) state_d = ST_V_FIN;
      ST_V_FIN:  state_d = ST_OUT;
      ST_FAIL:   state_d = ST_OUT;
      ST_OUT:    if (out_ready_i) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // command outputs
  always_comb begin
    cmd_o.op    = OP_NONE;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      ST_IDLE:   begin in_ready_o = 1'b1; if (in_valid_i) cmd_o.op = OP_LOAD; end
      ST_C_MQ:   cmd_o.op = OP_MUL_Q;
      ST_C_MQM:  cmd_o.op = OP_MUL_QM;
      ST_C_FIN:  cmd_o.op = OP_REDC_FIN;
      ST_C_SUB:  cmd_o.op = OP_SUB_MOD;
      ST_E_INIT: cmd_o.op = OP_EUC_INIT;
      ST_E_STEP: if (!status_i.euc_done) cmd_o.op = OP_EUC_STEP;
      ST_E_END:  if (status_i.gcd_one) cmd_o.op = OP_FIX_U;
      ST_F_MQ:   if (status_i.t_ge_w) cmd_o.op = OP_MUL_Q;
      ST_F_MQM:  cmd_o.op = OP_MUL_QM;
      ST_F_FIN:  cmd_o.op = OP_REDC_FIN;
      ST_V_MQ:   cmd_o.op = OP_MUL_QV;
      ST_V_MQM:  cmd_o.op = OP_MUL_QVM;
      ST_V_FIN:  cmd_o.op = OP_VAR_FIN;
      ST_FAIL:   cmd_o.op = OP_FAIL;
      ST_OUT:    out_valid_o = 1'b1;
      default: ;
    endcase
  end

  // handshake sanity
  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> state_q == ST_IDLE) else $error("ready outside idle");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o) else $error("result dropped");
  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o)) else $error("both sides open");

endmodule

[hdl/modular_inverse_binary_euclid.sv]
// channel   | valid/ready            | payload
// s_axis    | s_axis_tvalid/tready   | tdata[63:0] operand, tuser[0] mode
// m_axis    | m_axis_tvalid/tready   | tdata[63:0] inverse, tuser[0] ok
// cfg       | cfg_valid_i/cfg_ready_o| cfg_index_i, cfg_data_i
// one item at a time; euclid takes one subtract-shift step per cycle, at most
// 2*WORD_BITS-2 steps; a reduction is a multiply for q, a multiply by the
// modulus and a final step; the worst case from input to result is set by the
// euclid loop; out-of-range operands go from the check via the fail state to the result
// reset clears the controller and sets modulus 1, neg_modulus_inverse all ones
// result waits in place while m_axis_tready is low; no new item is taken then
module modular_inverse_binary_euclid
  import mibe_pkg::*;
#(
  parameter int unsigned WORD_BITS = WordBitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // operand
  input  logic        s_axis_tuser,   // mode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // inverse
  output logic        m_axis_tuser,   // ok
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [CfgIdxBits-1:0] cfg_index_i,
  input  logic [63:0] cfg_data_i
);

  logic [63:0] modulus_q, ninv_q;
  dp_cmd_t     cmd;
  dp_status_t  status;

  assign cfg_ready_o = 1'b1;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      modulus_q <= 64'd1;
      ninv_q    <= '1;
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_MODULUS: modulus_q <= cfg_data_i;
        REG_NINV:    ninv_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  mibe_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  mibe_datapath #(.WORD_BITS(WORD_BITS)) u_dp (
    .clk_i, .rst_ni,
    .cmd_i     (cmd),
    .mode_i    (s_axis_tuser),
    .operand_i (s_axis_tdata),
    .modulus_i (modulus_q),
    .ninv_i    (ninv_q),
    .status_o  (status),
    .inverse_o (m_axis_tdata),
    .ok_o      (m_axis_tuser)
  );

endmodule
